FILE: rtl/fapt_pkg.sv
// Shared types, codes and widths of the field access permission table.
package fapt_pkg;

  // Default sizes, handed to the top level parameters
  localparam int TABLE_DEPTH_DEF   = 64;
  localparam int FIELD_ID_BITS_DEF = 12;

  // Fixed field widths of the item and result
  localparam int MODE_W    = 2;
  localparam int PHASE_W   = 8;
  localparam int ACTOR_W   = 8;
  localparam int FIELD_W   = 12;
  localparam int KIND_W    = 2;
  localparam int STORAGE_W = 13;
  localparam int STATUS_W  = 4;
  localparam int USED_W    = 7;

  // Stream payload layout
  localparam int IN_TUSER_W  = MODE_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam int PHASE_LSB   = 0;
  localparam int ACTOR_LSB   = PHASE_LSB + PHASE_W;
  localparam int FIELD_LSB   = ACTOR_LSB + ACTOR_W;
  localparam int KIND_LSB    = FIELD_LSB + FIELD_W;
  localparam int STORAGE_LSB = KIND_LSB + KIND_W;
  localparam int IN_USED_W   = STORAGE_LSB + STORAGE_W;
  localparam int OUT_USED_W  = STATUS_W + USED_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_TOTAL = 1'd0,
    CFG_PLAN_LOCKED = 1'd1
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_DECLARE = 2'd0,
    MODE_CHK_RD  = 2'd1,
    MODE_CHK_WR  = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RW    = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 4'd0,
    ST_FROZEN        = 4'd1,
    ST_UNKNOWN_FIELD = 4'd2,
    ST_BAD_KIND      = 4'd3,
    ST_DUPLICATE     = 4'd4,
    ST_WRITER_EXISTS = 4'd5,
    ST_FULL          = 4'd6,
    ST_NOT_FROZEN    = 4'd7,
    ST_DOMAIN        = 4'd8,
    ST_UNDECLARED    = 4'd9,
    ST_NO_READ       = 4'd10,
    ST_NO_WRITE      = 4'd11
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_PRE   = 3'd1,
    S_SCAN  = 3'd2,
    S_DRAIN = 3'd3,
    S_FIN   = 3'd4
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // latch the accepted item, clear the scan results
    logic rd;     // read the table entry under the scan index
    logic fin;    // settle the status, commit, load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic early_ok;   // no refusal decided before the scan
    logic cnt_zero;   // table empty
    logic scan_last;  // scan index points at the last held entry
    logic out_free;   // result register can take a new result
  } dp_sts_t;

  function automatic logic kind_writes(input logic [KIND_W-1:0] k);
    kind_writes = (k == KIND_WRITE) || (k == KIND_RW);
  endfunction

endpackage

FILE: rtl/fapt_ctrl.sv
// Sequencer of the field access permission table: accept, scan, finish.
module fapt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  fapt_pkg::dp_sts_t sts,
  output fapt_pkg::dp_cmd_t cmd
);
  import fapt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_PRE;
      end
      S_PRE: begin
        if (!sts.early_ok || sts.cnt_zero) state_nxt = S_FIN;
        else                               state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_SCAN:  cmd.rd  = 1'b1;
      S_FIN:   cmd.fin = sts.out_free;
      default: cmd     = '0;
    endcase
  end

endmodule

FILE: rtl/fapt_dp.sv
// Datapath of the field access permission table: item, table, scan and result.
module fapt_dp #(
  parameter int TABLE_DEPTH   = fapt_pkg::TABLE_DEPTH_DEF,
  parameter int FIELD_ID_BITS = fapt_pkg::FIELD_ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [fapt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [fapt_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic [fapt_pkg::CFG_DATA_W-1:0]  field_total,
  input  logic                             plan_locked,
  input  fapt_pkg::dp_cmd_t                cmd,
  output fapt_pkg::dp_sts_t                sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fapt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import fapt_pkg::*;

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int FB   = FIELD_ID_BITS;
  localparam int CMPW = (FB > CFG_DATA_W) ? FB : CFG_DATA_W;
  localparam int EW   = PHASE_W + ACTOR_W + FB + KIND_W;

  // Latched item
  mode_t                mode_r;
  logic [PHASE_W-1:0]   ph_r;
  logic [ACTOR_W-1:0]   ac_r;
  logic [FB-1:0]        fd_r;
  logic [KIND_W-1:0]    kind_r;
  logic [STORAGE_W-1:0] stor_r;

  // Table and scan
  logic [EW-1:0]        mem [TABLE_DEPTH];
  logic [EW-1:0]        rd_data_r;
  logic                 rd_vld_r;
  logic [AW-1:0]        idx_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 found_r;
  logic [KIND_W-1:0]    fkind_r;
  logic                 wheld_r;

  // Result
  logic                 out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [PHASE_W-1:0]   e_ph;
  logic [ACTOR_W-1:0]   e_ac;
  logic [FB-1:0]        e_fd;
  logic [KIND_W-1:0]    e_kind;
  logic                 pf_eq, trip_eq;
  status_t              early_st, fin_st;
  logic                 commit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(in_tuser);
      ph_r   <= in_tdata[PHASE_LSB +: PHASE_W];
      ac_r   <= in_tdata[ACTOR_LSB +: ACTOR_W];
      fd_r   <= FB'(in_tdata[FIELD_LSB +: FIELD_W]);
      kind_r <= in_tdata[KIND_LSB +: KIND_W];
      stor_r <= in_tdata[STORAGE_LSB +: STORAGE_W];
    end
  end

  // Refusals that need no look at the table
  always_comb begin
    early_st = ST_OK;
    case (mode_r)
      MODE_DECLARE: begin
        if (plan_locked)
          early_st = ST_FROZEN;
        else if (CMPW'(fd_r) >= CMPW'(field_total))
          early_st = ST_UNKNOWN_FIELD;
        else if (!(kind_r inside {KIND_READ, KIND_WRITE, KIND_RW}))
          early_st = ST_BAD_KIND;
      end
      MODE_CHK_RD, MODE_CHK_WR: begin
        if (!plan_locked)
          early_st = ST_NOT_FROZEN;
        else if (field_total != stor_r)
          early_st = ST_DOMAIN;
      end
      default: early_st = ST_BAD_KIND;
    endcase
  end

  // Table memory, one read port for the scan
  always_ff @(posedge clk) begin
    if (cmd.rd) rd_data_r <= mem[idx_r];
    if (commit) mem[count_r[AW-1:0]] <= {ph_r, ac_r, fd_r, kind_r};
  end

  assign {e_ph, e_ac, e_fd, e_kind} = rd_data_r;
  assign pf_eq   = (e_ph == ph_r) && (e_fd == fd_r);
  assign trip_eq = pf_eq && (e_ac == ac_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      wheld_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.load) begin
        found_r <= 1'b0;
        wheld_r <= 1'b0;
        idx_r   <= '0;
      end else begin
        if (cmd.rd) idx_r <= idx_r + AW'(1);
        if (rd_vld_r) begin
          if (trip_eq && !found_r) begin
            found_r <= 1'b1;
            fkind_r <= e_kind;
          end
          if (pf_eq && kind_writes(e_kind)) wheld_r <= 1'b1;
        end
      end
    end
  end

  // Final status once the scan is over
  always_comb begin
    fin_st = early_st;
    if (early_st == ST_OK) begin
      case (mode_r)
        MODE_DECLARE: begin
          if (found_r)                                 fin_st = ST_DUPLICATE;
          else if (kind_writes(kind_r) && wheld_r)     fin_st = ST_WRITER_EXISTS;
          else if (count_r == CW'(TABLE_DEPTH))        fin_st = ST_FULL;
        end
        MODE_CHK_RD: begin
          if (!found_r)                  fin_st = ST_UNDECLARED;
          else if (fkind_r == KIND_WRITE) fin_st = ST_NO_READ;
        end
        MODE_CHK_WR: begin
          if (!found_r)                  fin_st = ST_UNDECLARED;
          else if (fkind_r == KIND_READ) fin_st = ST_NO_WRITE;
        end
        default: fin_st = ST_BAD_KIND;
      endcase
    end
  end

  assign commit    = cmd.fin && (mode_r == MODE_DECLARE) && (fin_st == ST_OK);
  assign count_nxt = commit ? count_r + CW'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.fin)        out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin)
      out_data_r <= OUT_TDATA_W'({USED_W'(count_nxt), fin_st});
  end

  assign out_tvalid    = out_vld_r;
  assign out_tdata     = out_data_r;
  assign sts.early_ok  = (early_st == ST_OK);
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.scan_last = (CW'(idx_r) == count_r - CW'(1));
  assign sts.out_free  = !out_vld_r || out_tready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("declaration count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1)) && $past(cmd.fin))
    else $error("declaration count moved other than by one append");

  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> !out_vld_r || out_tready)
    else $error("result loaded over one not yet taken");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> CW'(idx_r) < count_r)
    else $error("scan read beyond the held declarations");
`endif

endmodule

FILE: rtl/field_access_permission_table.sv
// Top level of the field access permission table.
//
// The block holds up to TABLE_DEPTH access declarations (phase, actor,
// field, kind) and answers each input item with exactly one result item
// carrying a status code and the number of declarations held after the
// item. Declare items (mode 0) append a declaration unless the plan is
// locked, the field lies outside field_total, the kind is unrecognised,
// the triple is already held, a writing item meets a held writer of that
// phase and field, or the table is full. Read and write checks (modes 1
// and 2) need a locked plan and a storage field count equal to field_total,
// then look the triple up and refuse a read of a write-only entry or a
// write of a read-only entry. Mode 3 answers bad kind and changes nothing.
// One item is worked on at a time: it passes a pre-check, a search of the
// held declarations, a drain and a finish state; a refusal that needs no
// search, or an empty table, skips to the finish. The finish waits until
// the result register is free; the next item is taken in the idle state
// after a result is loaded. The search reads the table through its single
// read port, one entry a cycle. A finished result waits in its output
// register while the next item is accepted. The table needs no clearing
// after reset; only entries below the count are ever read.
// Configuration: index 0 is field_total (13 bits), index 1 is plan_locked
// (bit 0); write it only while the block is idle.
module field_access_permission_table #(
  parameter int TABLE_DEPTH   = fapt_pkg::TABLE_DEPTH_DEF,
  parameter int FIELD_ID_BITS = fapt_pkg::FIELD_ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] phase_id, [15:8] actor_id, [27:16] field_id,
  // [29:28] access_kind, [42:30] storage_fields, [47:43] zero
  input  logic [fapt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  logic [fapt_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] status, [10:4] entries_used, [15:11] zero
  output logic [fapt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fapt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fapt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fapt_pkg::*;

  logic [CFG_DATA_W-1:0] field_total_r;
  logic                  plan_locked_r;
  dp_cmd_t               cmd;
  dp_sts_t               sts;

  // Configuration registers; writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_total_r <= '0;
      plan_locked_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FIELD_TOTAL: field_total_r <= cfg_data;
        CFG_PLAN_LOCKED: plan_locked_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequence each item: latch, search the table, settle the result
  fapt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the item, the declaration table and the result register
  fapt_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FIELD_ID_BITS (FIELD_ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .field_total (field_total_r),
    .plan_locked (plan_locked_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while another is at work");

  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_tvalid && in_tready)
    else $error("item latched without a handshake");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd, cmd.fin}))
    else $error("controller issued conflicting commands");
`endif

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the field access permission table.
module tb;
  import fapt_pkg::*;

  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int ITEM_TARGET  = 1850;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int IDLE_CYCLES  = 8;    // pause before a register write
  localparam int DRAIN_CYCLES = 100;  // allowance beyond a full-table search
  localparam int HOLD_CYCLES  = 600;  // long receiver hold-off

  // Codes the package leaves out: the unused mode and the unrecognised kind
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [KIND_W-1:0] KIND_BAD    = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [PHASE_W-1:0]   phase;
    logic [ACTOR_W-1:0]   actor;
    logic [FIELD_W-1:0]   field;
    logic [KIND_W-1:0]    kind;
    logic [STORAGE_W-1:0] storage;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [USED_W-1:0] used;
  } verdict_t;

  // One held declaration: phase, actor, field, kind (30 bits)
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [ACTOR_W-1:0] actor;
    logic [FIELD_W-1:0] field;
    logic [KIND_W-1:0]  kind;
  } decl_t;

  // A directed step: optional register setting first, then one item
  typedef struct packed {
    logic                 reconf;
    logic [STORAGE_W-1:0] ft;
    logic                 lock;
    item_t                it;
    logic                 typed;
    verdict_t             want;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor state: the declarations held and the register copies
  decl_t                decl_store [TABLE_DEPTH];
  logic [USED_W-1:0]    decl_count = '0;
  logic [STORAGE_W-1:0] field_total = '0;
  logic                 plan_locked = 1'b0;

  verdict_t verdict_q [$];
  int       items_sent = 0;
  int       fail_count = 0;

  field_access_permission_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Directed steps. Expected verdicts are typed in for reset values,
  // extremes and refusals; the rest fall back on the predictor.
  localparam int SCRIPT_LEN = 25;
  probe_t script [SCRIPT_LEN] = '{
    // reset values: empty domain, plan open
    '{1'b0, 13'd0, 1'b0, '{MODE_DECLARE, 8'd0, 8'd0, 12'd0, KIND_READ, 13'd0},
      1'b1, '{ST_UNKNOWN_FIELD, 7'd0}},
    '{1'b0, 13'd0, 1'b0, '{MODE_CHK_RD, 8'd0, 8'd0, 12'd0, KIND_READ, 13'd0},
      1'b1, '{ST_NOT_FROZEN, 7'd0}},
    '{1'b0, 13'd0, 1'b0, '{MODE_UNUSED, 8'd0, 8'd0, 12'd0, KIND_READ, 13'd0},
      1'b1, '{ST_BAD_KIND, 7'd0}},
    // widest domain, plan open: fill a few entries, hit several refusals
    '{1'b1, 13'd4096, 1'b0, '{MODE_DECLARE, 8'd0, 8'd0, 12'd0, KIND_READ, 13'd0},
      1'b0, '{ST_OK, 7'd0}},
    '{1'b0, 13'd4096, 1'b0,
      '{MODE_DECLARE, 8'd255, 8'd255, 12'd4095, KIND_WRITE, 13'd4096},
      1'b0, '{ST_OK, 7'd0}},
    '{1'b0, 13'd4096, 1'b0, '{MODE_DECLARE, 8'd1, 8'd2, 12'd3, KIND_BAD, 13'd0},
      1'b1, '{ST_BAD_KIND, 7'd2}},
    '{1'b0, 13'd4096, 1'b0, '{MODE_DECLARE, 8'd0, 8'd0, 12'd0, KIND_WRITE, 13'd0},
      1'b1, '{ST_DUPLICATE, 7'd2}},
    '{1'b0, 13'd4096, 1'b0, '{MODE_DECLARE, 8'd255, 8'd0, 12'd4095, KIND_RW, 13'd0},
      1'b1, '{ST_WRITER_EXISTS, 7'd2}},
    '{1'b0, 13'd4096, 1'b0, '{MODE_DECLARE, 8'd255, 8'd1, 12'd4095, KIND_READ, 13'd0},
      1'b0, '{ST_OK, 7'd0}},
    '{1'b0, 13'd4096, 1'b0, '{MODE_DECLARE, 8'd0, 8'd1, 12'd0, KIND_RW, 13'd0},
      1'b0, '{ST_OK, 7'd0}},
    '{1'b0, 13'd4096, 1'b0, '{MODE_CHK_WR, 8'd0, 8'd1, 12'd0, KIND_READ, 13'd4096},
      1'b1, '{ST_NOT_FROZEN, 7'd4}},
    '{1'b0, 13'd4096, 1'b0, '{MODE_UNUSED, 8'd0, 8'd1, 12'd0, KIND_RW, 13'd4096},
      1'b1, '{ST_BAD_KIND, 7'd4}},
    // one-field domain: field 1 is already outside it
    '{1'b1, 13'd1, 1'b0, '{MODE_DECLARE, 8'd7, 8'd7, 12'd1, KIND_READ, 13'd0},
      1'b1, '{ST_UNKNOWN_FIELD, 7'd4}},
    '{1'b0, 13'd1, 1'b0, '{MODE_DECLARE, 8'd7, 8'd7, 12'd0, KIND_WRITE, 13'd0},
      1'b0, '{ST_OK, 7'd0}},
    // plan locked: checks against the held entries
    '{1'b1, 13'd4096, 1'b1, '{MODE_DECLARE, 8'd9, 8'd9, 12'd9, KIND_READ, 13'd0},
      1'b1, '{ST_FROZEN, 7'd5}},
    '{1'b0, 13'd4096, 1'b1,
      '{MODE_CHK_RD, 8'd255, 8'd255, 12'd4095, KIND_READ, 13'd4096},
      1'b1, '{ST_NO_READ, 7'd5}},
    '{1'b0, 13'd4096, 1'b1, '{MODE_CHK_WR, 8'd0, 8'd0, 12'd0, KIND_RW, 13'd4096},
      1'b1, '{ST_NO_WRITE, 7'd5}},
    '{1'b0, 13'd4096, 1'b1, '{MODE_CHK_WR, 8'd0, 8'd1, 12'd0, KIND_READ, 13'd4096},
      1'b0, '{ST_OK, 7'd0}},
    '{1'b0, 13'd4096, 1'b1, '{MODE_CHK_RD, 8'd0, 8'd0, 12'd0, KIND_BAD, 13'd4096},
      1'b0, '{ST_OK, 7'd0}},
    '{1'b0, 13'd4096, 1'b1,
      '{MODE_CHK_RD, 8'd255, 8'd1, 12'd4095, KIND_READ, 13'd4095},
      1'b1, '{ST_DOMAIN, 7'd5}},
    '{1'b0, 13'd4096, 1'b1, '{MODE_CHK_RD, 8'd255, 8'd1, 12'd4095, KIND_READ, 13'd0},
      1'b1, '{ST_DOMAIN, 7'd5}},
    '{1'b0, 13'd4096, 1'b1, '{MODE_CHK_WR, 8'd1, 8'd1, 12'd1, KIND_READ, 13'd4096},
      1'b1, '{ST_UNDECLARED, 7'd5}},
    '{1'b0, 13'd4096, 1'b1,
      '{MODE_CHK_WR, 8'd255, 8'd255, 12'd4095, KIND_READ, 13'd4096},
      1'b0, '{ST_OK, 7'd0}},
    '{1'b0, 13'd4096, 1'b1,
      '{MODE_CHK_RD, 8'd255, 8'd254, 12'd4095, KIND_READ, 13'd4096},
      1'b1, '{ST_UNDECLARED, 7'd5}},
    '{1'b0, 13'd4096, 1'b1, '{MODE_UNUSED, 8'd255, 8'd255, 12'd4095, KIND_BAD, 13'd4096},
      1'b1, '{ST_BAD_KIND, 7'd5}}
  };

  // Index of the held declaration with this triple, or -1
  function automatic int find_decl(logic [PHASE_W-1:0] ph, logic [ACTOR_W-1:0] ac,
                                   logic [FIELD_W-1:0] fd);
    for (int i = 0; i < decl_count; i++) begin
      if (decl_store[i].phase == ph && decl_store[i].actor == ac &&
          decl_store[i].field == fd)
        return i;
    end
    return -1;
  endfunction

  // Work out the verdict for one accepted item and advance the table copy
  function automatic verdict_t arbitrate_access(item_t it);
    verdict_t v;
    int       hit;
    logic     writer;
    v.status = ST_OK;
    writer = 1'b0;
    case (it.mode)
      MODE_DECLARE: begin
        // a writer only clashes with another writer of the same phase and field
        if (it.kind == KIND_WRITE || it.kind == KIND_RW) begin
          for (int i = 0; i < decl_count; i++) begin
            if (decl_store[i].phase == it.phase && decl_store[i].field == it.field &&
                (decl_store[i].kind == KIND_WRITE || decl_store[i].kind == KIND_RW))
              writer = 1'b1;
          end
        end
        if (plan_locked) v.status = ST_FROZEN;
        else if (it.field >= field_total) v.status = ST_UNKNOWN_FIELD;
        else if (it.kind == KIND_BAD) v.status = ST_BAD_KIND;
        else if (find_decl(it.phase, it.actor, it.field) >= 0) v.status = ST_DUPLICATE;
        else if (writer) v.status = ST_WRITER_EXISTS;
        else if (decl_count >= TABLE_DEPTH) v.status = ST_FULL;
        else begin
          decl_store[decl_count] = {it.phase, it.actor, it.field, it.kind};
          decl_count++;
        end
      end
      MODE_CHK_RD, MODE_CHK_WR: begin
        hit = find_decl(it.phase, it.actor, it.field);
        if (!plan_locked) v.status = ST_NOT_FROZEN;
        else if (field_total != it.storage) v.status = ST_DOMAIN;
        else if (hit < 0) v.status = ST_UNDECLARED;
        else if (it.mode == MODE_CHK_RD && decl_store[hit].kind == KIND_WRITE)
          v.status = ST_NO_READ;
        else if (it.mode == MODE_CHK_WR && decl_store[hit].kind == KIND_READ)
          v.status = ST_NO_WRITE;
      end
      default: v.status = ST_BAD_KIND;
    endcase
    v.used = decl_count;
    return v;
  endfunction

  // Random item: mostly well-formed for the current plan state, with
  // small id pools so that duplicates and writer clashes keep turning up
  function automatic item_t draw_item();
    item_t it;
    int    roll;
    int    pick;
    roll = $urandom_range(0, 99);
    it.phase   = 8'($urandom_range(0, 255));
    it.actor   = 8'($urandom_range(0, 255));
    it.field   = 12'($urandom_range(0, 4095));
    it.kind    = 2'($urandom_range(0, 3));
    it.storage = 13'($urandom_range(0, 4096));
    if (roll < 4) begin
      it.mode = MODE_UNUSED;
    end else if ((!plan_locked && roll < 80) || (plan_locked && roll < 16)) begin
      it.mode = MODE_DECLARE;
      if ($urandom_range(0, 9) < 7) begin
        it.phase = 8'($urandom_range(0, 3));
        it.actor = 8'($urandom_range(0, 3));
        it.field = 12'($urandom_range(0, 7));
      end
      it.kind = ($urandom_range(0, 9) == 0) ? KIND_BAD : 2'($urandom_range(0, 2));
    end else begin
      it.mode = $urandom_range(0, 1) ? MODE_CHK_WR : MODE_CHK_RD;
      if ($urandom_range(0, 4) != 0) it.storage = field_total;
      if (decl_count != 0 && $urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, decl_count - 1);
        it.phase = decl_store[pick].phase;
        it.actor = decl_store[pick].actor;
        it.field = decl_store[pick].field;
      end
    end
    return it;
  endfunction

  // Offer one item and hold it until accepted; valid stays high on return
  task automatic offer_item(input item_t it, input logic typed, input verdict_t want);
    verdict_t v;
    in_tuser  <= it.mode;
    in_tdata  <= {5'd0, it.storage, it.kind, it.field, it.actor, it.phase};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = arbitrate_access(it);
    verdict_q.insert(verdict_q.size(), typed ? want : v);
    items_sent++;
  endtask

  // Drop valid and wait until every verdict is in, then let the block settle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high between the two
  task automatic reconfigure(input logic [STORAGE_W-1:0] ft, input logic lock);
    cfg_index <= CFG_FIELD_TOTAL;
    cfg_data  <= ft;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    field_total = ft;
    cfg_index <= CFG_PLAN_LOCKED;
    cfg_data  <= {12'd0, lock};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    plan_locked = lock;
    cfg_valid <= 1'b0;
  endtask

  // Stream n random items in bursts; some phases run without gaps
  task automatic pump_items(input int n);
    int   burst;
    int   gap;
    logic steady;
    steady = ($urandom_range(0, 4) == 0);
    burst  = $urandom_range(1, 24);
    for (int k = 0; k < n; k++) begin
      offer_item(draw_item(), 1'b0, '0);
      burst--;
      if (!steady && burst == 0) begin
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
    end
  endtask

  // Receiver: switch between stall patterns now and then, and twice hold
  // off for a long stretch so that the block backs up into its input
  initial begin : receiver
    int pat;
    int left;
    int holds;
    pat   = 0;
    left  = 0;
    holds = 0;
    forever begin
      @(posedge clk);
      if ((holds == 0 && items_sent >= 300) || (holds == 1 && items_sent >= 1300)) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds++;
      end
      if (left == 0) begin
        pat  = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      case (pat)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Compare each result item, field by field, with the oldest verdict
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result item: status %0d, entries_used %0d",
               out_tdata[3:0], out_tdata[10:4]);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[3:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[3:0]);
          fail_count++;
        end
        if (out_tdata[10:4] !== want.used) begin
          $error("entries_used: expected %0d, got %0d", want.used, out_tdata[10:4]);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [STORAGE_W-1:0] ft;
    logic                 lock;
    int                   sel;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the script, resetting registers where a row asks
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (script[r].reconf) begin
        quiesce();
        reconfigure(script[r].ft, script[r].lock);
      end
      offer_item(script[r].it, script[r].typed, script[r].want);
    end

    // Random part: phases of random register settings, the extremes
    // among them; the plan stays mostly open until the table is full
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       ft = 13'd0;
        1:       ft = 13'd1;
        2, 3:    ft = 13'd4096;
        4, 5, 6: ft = 13'($urandom_range(2, 64));
        default: ft = 13'($urandom_range(1, 4096));
      endcase
      if (decl_count < TABLE_DEPTH) lock = ($urandom_range(0, 3) == 0);
      else lock = 1'($urandom_range(0, 1));
      quiesce();
      reconfigure(ft, lock);
      pump_items($urandom_range(40, 120));
    end

    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fapt_pkg.sv
rtl/fapt_ctrl.sv
rtl/fapt_dp.sv
rtl/field_access_permission_table.sv
sim/tb.sv
